>>> rtl/pstsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pstsd_pkg
// Shared widths and inter-stage types for the point to segment distance pipe.
// ----------------------------------------------------------------------------
package pstsd_pkg;

  localparam int CW        = 24;          // coordinate width
  localparam int DW        = CW + 1;      // coordinate difference width
  localparam int PW        = 2 * DW;      // signed product width
  localparam int SUMW      = 2 * CW + 2;  // squared-length / |dot| width
  localparam int HW        = SUMW / 2;    // partial product half width
  localparam int NW        = 2 * SUMW;    // numerator width
  localparam int RW        = SUMW / 2;    // root width, equals distance width
  localparam int DIV_STEPS = SUMW;
  localparam int SQ_STEPS  = RW;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by;
    coord_t bz;
    coord_t qx;
    coord_t qy;
    coord_t qz;
  } query_t;

  typedef struct packed {
    logic [NW-1:0]   num;
    logic [SUMW-1:0] den;
    logic [SUMW-1:0] alt;
    logic            use_alt;
    logic            deg;
  } divin_t;

  typedef struct packed {
    logic [SUMW-1:0] quo;
    logic [SUMW-1:0] alt;
    logic            use_alt;
    logic            deg;
  } divout_t;

  typedef struct packed {
    logic [RW-1:0]   root;
    logic [RW+1:0]   rem;
    logic            deg;
  } sqout_t;

endpackage
`default_nettype wire

>>> rtl/point_to_segment_distance_3d.sv
`default_nettype none
// ----------------------------------------------------------------------------
// point_to_segment_distance_3d
// Pipeline: 7 geometry stages, 50 divider stages, 25 square root stages and
// 1 output register between input accept and output valid.
// Throughput: one item per cycle; the whole pipe holds while the output
// register is full and stalled.
// Reset: synchronous active-low rst_n clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module point_to_segment_distance_3d
  import pstsd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [CW-1:0] in_seg_a_x,
  input  wire logic [CW-1:0] in_seg_a_y,
  input  wire logic [CW-1:0] in_seg_a_z,
  input  wire logic [CW-1:0] in_seg_b_x,
  input  wire logic [CW-1:0] in_seg_b_y,
  input  wire logic [CW-1:0] in_seg_b_z,
  input  wire logic [CW-1:0] in_query_x,
  input  wire logic [CW-1:0] in_query_y,
  input  wire logic [CW-1:0] in_query_z,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [RW-1:0]      out_distance,
  output logic               out_segment_degenerate
);

  logic    en;
  query_t  q;
  logic    g_vld, d_vld, s_vld;
  divin_t  g_d;
  divout_t d_d;
  sqout_t  s_d;
  logic    out_valid_r;
  logic [RW-1:0] dist_r;
  logic    deg_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_comb begin
    q.ax = in_seg_a_x;
    q.ay = in_seg_a_y;
    q.az = in_seg_a_z;
    q.bx = in_seg_b_x;
    q.by = in_seg_b_y;
    q.bz = in_seg_b_z;
    q.qx = in_query_x;
    q.qy = in_query_y;
    q.qz = in_query_z;
  end

  pstsd_geom u_geom (
    .clk, .rst_n, .en,
    .in_vld (in_valid),
    .in_q   (q),
    .out_vld(g_vld),
    .out_d  (g_d)
  );

  pstsd_div u_div (
    .clk, .rst_n, .en,
    .in_vld (g_vld),
    .in_d   (g_d),
    .out_vld(d_vld),
    .out_d  (d_d)
  );

  pstsd_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .in_vld (d_vld),
    .in_d   (d_d),
    .out_vld(s_vld),
    .out_d  (s_d)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s_vld;
    end
  end

  // round to nearest: up when remainder exceeds root
  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= s_d.root + RW'(s_d.rem > {2'b00, s_d.root});
      deg_r  <= s_d.deg;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_distance           = dist_r;
  assign out_segment_degenerate = deg_r;

endmodule
`default_nettype wire

>>> rtl/pstsd_geom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pstsd_geom
// Seven stages: differences, products, sums, base select, wide partial
// products, product sums, perpendicular numerator with clamp.
// ----------------------------------------------------------------------------
module pstsd_geom
  import pstsd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   en,
  input  wire logic   in_vld,
  input  wire query_t in_q,
  output logic        out_vld,
  output divin_t      out_d
);

  function automatic logic signed [DW-1:0] sx(input coord_t c);
    sx = {c[CW-1], c};
  endfunction

  logic [6:0] v_r;

  // stage 1
  logic signed [DW-1:0] da_r [3];
  logic signed [DW-1:0] db_r [3];
  logic signed [DW-1:0] w_r  [3];
  // stage 2
  logic signed [PW-1:0] sa_r [3];
  logic signed [PW-1:0] sb_r [3];
  logic signed [PW-1:0] sw_r [3];
  logic signed [PW-1:0] pa_r [3];
  logic signed [PW-1:0] pb_r [3];
  // stage 3
  logic [SUMW-1:0]      d0_r, d1_r, l3_r;
  logic signed [SUMW:0] dota_r, dotb_r;
  // stage 4
  logic [SUMW-1:0]      bsq_r, nsq_r, adot_r, l4_r;
  logic                 deg4_r;
  // stage 5
  logic [2*HW-1:0]      pp1_r [4];
  logic [2*HW-1:0]      pp2_r [4];
  logic [SUMW-1:0]      l5_r, alt5_r;
  logic                 ua5_r, deg5_r;
  // stage 6
  logic [NW-1:0]        p1_r, p2_r;
  logic [SUMW-1:0]      l6_r, alt6_r;
  logic                 ua6_r, deg6_r;
  // stage 7
  divin_t               d7_r;

  logic                 base_a;
  logic [SUMW:0]        abs_a, abs_b;
  logic [NW:0]          df;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      da_r[0] <= sx(in_q.ax) - sx(in_q.qx);
      da_r[1] <= sx(in_q.ay) - sx(in_q.qy);
      da_r[2] <= sx(in_q.az) - sx(in_q.qz);
      db_r[0] <= sx(in_q.bx) - sx(in_q.qx);
      db_r[1] <= sx(in_q.by) - sx(in_q.qy);
      db_r[2] <= sx(in_q.bz) - sx(in_q.qz);
      w_r[0]  <= sx(in_q.bx) - sx(in_q.ax);
      w_r[1]  <= sx(in_q.by) - sx(in_q.ay);
      w_r[2]  <= sx(in_q.bz) - sx(in_q.az);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sa_r[i] <= da_r[i] * da_r[i];
        sb_r[i] <= db_r[i] * db_r[i];
        sw_r[i] <= w_r[i] * w_r[i];
        pa_r[i] <= w_r[i] * da_r[i];
        pb_r[i] <= w_r[i] * db_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0_r   <= SUMW'($unsigned(sa_r[0])) + SUMW'($unsigned(sa_r[1]))
              + SUMW'($unsigned(sa_r[2]));
      d1_r   <= SUMW'($unsigned(sb_r[0])) + SUMW'($unsigned(sb_r[1]))
              + SUMW'($unsigned(sb_r[2]));
      l3_r   <= SUMW'($unsigned(sw_r[0])) + SUMW'($unsigned(sw_r[1]))
              + SUMW'($unsigned(sw_r[2]));
      dota_r <= (SUMW+1)'(pa_r[0]) + (SUMW+1)'(pa_r[1]) + (SUMW+1)'(pa_r[2]);
      dotb_r <= (SUMW+1)'(pb_r[0]) + (SUMW+1)'(pb_r[1]) + (SUMW+1)'(pb_r[2]);
    end
  end

  // base is A when A is strictly farther; dot sign is dropped by the abs
  always_comb begin
    base_a = d0_r > d1_r;
    abs_a  = dota_r[SUMW] ? (SUMW+1)'(-dota_r) : $unsigned(dota_r);
    abs_b  = dotb_r[SUMW] ? (SUMW+1)'(-dotb_r) : $unsigned(dotb_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bsq_r  <= base_a ? d0_r : d1_r;
      nsq_r  <= base_a ? d1_r : d0_r;
      adot_r <= base_a ? abs_a[SUMW-1:0] : abs_b[SUMW-1:0];
      l4_r   <= l3_r;
      deg4_r <= l3_r == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp1_r[0] <= bsq_r[HW-1:0]    * l4_r[HW-1:0];
      pp1_r[1] <= bsq_r[HW-1:0]    * l4_r[SUMW-1:HW];
      pp1_r[2] <= bsq_r[SUMW-1:HW] * l4_r[HW-1:0];
      pp1_r[3] <= bsq_r[SUMW-1:HW] * l4_r[SUMW-1:HW];
      pp2_r[0] <= adot_r[HW-1:0]    * adot_r[HW-1:0];
      pp2_r[1] <= adot_r[HW-1:0]    * adot_r[SUMW-1:HW];
      pp2_r[2] <= adot_r[SUMW-1:HW] * adot_r[HW-1:0];
      pp2_r[3] <= adot_r[SUMW-1:HW] * adot_r[SUMW-1:HW];
      l5_r     <= l4_r;
      alt5_r   <= deg4_r ? bsq_r : nsq_r;
      ua5_r    <= deg4_r || (adot_r > l4_r);
      deg5_r   <= deg4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r   <= NW'(pp1_r[0]) + (NW'(pp1_r[1]) << HW) + (NW'(pp1_r[2]) << HW)
              + (NW'(pp1_r[3]) << SUMW);
      p2_r   <= NW'(pp2_r[0]) + (NW'(pp2_r[1]) << HW) + (NW'(pp2_r[2]) << HW)
              + (NW'(pp2_r[3]) << SUMW);
      l6_r   <= l5_r;
      alt6_r <= alt5_r;
      ua6_r  <= ua5_r;
      deg6_r <= deg5_r;
    end
  end

  assign df = {1'b0, p1_r} - {1'b0, p2_r};

  always_ff @(posedge clk) begin
    if (en) begin
      d7_r.num     <= df[NW] ? '0 : df[NW-1:0];
      d7_r.den     <= l6_r;
      d7_r.alt     <= alt6_r;
      d7_r.use_alt <= ua6_r;
      d7_r.deg     <= deg6_r;
    end
  end

  assign out_vld = v_r[6];
  assign out_d   = d7_r;

endmodule
`default_nettype wire

>>> rtl/pstsd_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pstsd_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pstsd_div
  import pstsd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   en,
  input  wire logic   in_vld,
  input  wire divin_t in_d,
  output logic        out_vld,
  output divout_t     out_d
);

  typedef struct packed {
    logic [SUMW-1:0] rem;
    logic [SUMW-1:0] lo;
    logic [SUMW-1:0] quo;
    logic [SUMW-1:0] den;
    logic [SUMW-1:0] alt;
    logic            use_alt;
    logic            deg;
  } divst_t;

  logic [DIV_STEPS-1:0] v_r;
  divst_t cur   [DIV_STEPS];
  divst_t st_r  [DIV_STEPS];
  divst_t st_nxt[DIV_STEPS];

  always_comb begin
    cur[0].rem     = in_d.num[NW-1:SUMW];
    cur[0].lo      = in_d.num[SUMW-1:0];
    cur[0].quo     = '0;
    cur[0].den     = in_d.den;
    cur[0].alt     = in_d.alt;
    cur[0].use_alt = in_d.use_alt;
    cur[0].deg     = in_d.deg;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [SUMW:0] t;
    logic          ge;

    if (k > 0) begin : g_link
      assign cur[k] = st_r[k-1];
    end

    always_comb begin
      t  = {cur[k].rem, cur[k].lo[SUMW-1]};
      ge = t >= {1'b0, cur[k].den};
      st_nxt[k]     = cur[k];
      st_nxt[k].rem = ge ? SUMW'(t - {1'b0, cur[k].den}) : t[SUMW-1:0];
      st_nxt[k].lo  = cur[k].lo << 1;
      st_nxt[k].quo = {cur[k].quo[SUMW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DIV_STEPS-2:0], in_vld};
    end
  end

  assign out_vld       = v_r[DIV_STEPS-1];
  assign out_d.quo     = st_r[DIV_STEPS-1].quo;
  assign out_d.alt     = st_r[DIV_STEPS-1].alt;
  assign out_d.use_alt = st_r[DIV_STEPS-1].use_alt;
  assign out_d.deg     = st_r[DIV_STEPS-1].deg;

endmodule
`default_nettype wire

>>> rtl/pstsd_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pstsd_sqrt
// Pipelined digit-by-digit square root, one root bit per stage. Picks the
// endpoint square in place of the quotient when the item needs it.
// ----------------------------------------------------------------------------
module pstsd_sqrt
  import pstsd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire logic    in_vld,
  input  wire divout_t in_d,
  output logic         out_vld,
  output sqout_t       out_d
);

  typedef struct packed {
    logic [SUMW-1:0] x;
    logic [RW-1:0]   root;
    logic [RW+1:0]   rem;
    logic            deg;
  } sqst_t;

  logic [SQ_STEPS-1:0] v_r;
  sqst_t cur   [SQ_STEPS];
  sqst_t st_r  [SQ_STEPS];
  sqst_t st_nxt[SQ_STEPS];

  always_comb begin
    cur[0].x    = in_d.use_alt ? in_d.alt : in_d.quo;
    cur[0].root = '0;
    cur[0].rem  = '0;
    cur[0].deg  = in_d.deg;
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic [RW+3:0] t;
    logic [RW+3:0] sub;
    logic          ge;

    if (k > 0) begin : g_link
      assign cur[k] = st_r[k-1];
    end

    always_comb begin
      t   = {cur[k].rem, cur[k].x[SUMW-1:SUMW-2]};
      sub = {2'b00, cur[k].root, 2'b01};
      ge  = t >= sub;
      st_nxt[k]      = cur[k];
      st_nxt[k].rem  = ge ? (RW+2)'(t - sub) : t[RW+1:0];
      st_nxt[k].root = {cur[k].root[RW-2:0], ge};
      st_nxt[k].x    = cur[k].x << 2;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[SQ_STEPS-2:0], in_vld};
    end
  end

  assign out_vld    = v_r[SQ_STEPS-1];
  assign out_d.root = st_r[SQ_STEPS-1].root;
  assign out_d.rem  = st_r[SQ_STEPS-1].rem;
  assign out_d.deg  = st_r[SQ_STEPS-1].deg;

endmodule
`default_nettype wire

>>> tb/sv/point_to_segment_distance_3d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_to_segment_distance_3d_checker
// Watches both channels, predicts each query's distance and degenerate flag
// with exact integer math and compares results in order.
// ----------------------------------------------------------------------------
module point_to_segment_distance_3d_checker
  import pstsd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_stall,
  input  wire logic [CW-1:0] in_seg_a_x,
  input  wire logic [CW-1:0] in_seg_a_y,
  input  wire logic [CW-1:0] in_seg_a_z,
  input  wire logic [CW-1:0] in_seg_b_x,
  input  wire logic [CW-1:0] in_seg_b_y,
  input  wire logic [CW-1:0] in_seg_b_z,
  input  wire logic [CW-1:0] in_query_x,
  input  wire logic [CW-1:0] in_query_y,
  input  wire logic [CW-1:0] in_query_z,
  input  wire logic          out_valid,
  input  wire logic          out_stall,
  input  wire logic [RW-1:0] out_distance,
  input  wire logic          out_segment_degenerate,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen,
  output int                 degenerate_seen
);

  typedef struct packed {
    logic [RW-1:0] distance;
    logic          degenerate;
  } dist_result_t;

  dist_result_t dist_queue[$];

  function automatic logic [127:0] root_nearest(logic [127:0] n);
    logic [127:0] lo, hi, mid;
    lo = 0;
    hi = 128'd1 << 64;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= n) lo = mid;
      else hi = mid;
    end
    if (n - lo * lo > lo) lo = lo + 1;
    return lo;
  endfunction

  function automatic dist_result_t predict_distance(
      logic signed [CW-1:0] ax, ay, az, bx, by, bz, qx, qy, qz);
    logic signed [127:0] sx, sy, sz, ex, ey, ez, dot;
    logic [127:0] d0, d1, bsq, nsq, lsq, adot, num, d;
    dist_result_t r;
    d0 = (128'(ax) - qx) ** 2 + (128'(ay) - qy) ** 2 + (128'(az) - qz) ** 2;
    d1 = (128'(bx) - qx) ** 2 + (128'(by) - qy) ** 2 + (128'(bz) - qz) ** 2;
    if (d0 > d1) begin
      sx = ax; sy = ay; sz = az; ex = bx; ey = by; ez = bz; bsq = d0;
    end else begin
      sx = bx; sy = by; sz = bz; ex = ax; ey = ay; ez = az; bsq = d1;
    end
    nsq = (d0 < d1) ? d0 : d1;
    lsq = (ex - sx) ** 2 + (ey - sy) ** 2 + (ez - sz) ** 2;
    dot = (ex - sx) * (qx - sx) + (ey - sy) * (qy - sy) + (ez - sz) * (qz - sz);
    adot = (dot < 0) ? -dot : dot;
    r.degenerate = 1'b0;
    if (lsq == 0) begin
      d = root_nearest(bsq);
      r.degenerate = 1'b1;
    end else if (adot > lsq) begin
      d = root_nearest(nsq);
    end else begin
      num = (bsq * lsq < adot * adot) ? 128'd0 : bsq * lsq - adot * adot;
      d = root_nearest(num / lsq);
    end
    r.distance = d[RW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    dist_result_t e;
    int nf;
    nf = 0;
    if (!rst_n) begin
      fail_count <= 0;
      results_seen <= 0;
      degenerate_seen <= 0;
    end else begin
      if (in_valid && !in_stall)
        dist_queue.push_back(predict_distance(in_seg_a_x, in_seg_a_y, in_seg_a_z,
            in_seg_b_x, in_seg_b_y, in_seg_b_z, in_query_x, in_query_y, in_query_z));
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (dist_queue.size() == 0) begin
          $error("unexpected item: distance %0d", out_distance);
          nf = nf + 1;
        end else begin
          e = dist_queue.pop_front();
          if (e.degenerate) degenerate_seen <= degenerate_seen + 1;
          if (out_distance !== e.distance) begin
            $error("distance expected %0d actual %0d", e.distance, out_distance);
            nf = nf + 1;
          end
          if (out_segment_degenerate !== e.degenerate) begin
            $error("segment_degenerate expected %0d actual %0d", e.degenerate,
                out_segment_degenerate);
            nf = nf + 1;
          end
        end
      end
      fail_count <= fail_count + nf;
    end
    pending <= dist_queue.size();
  end

endmodule

>>> tb/sv/point_to_segment_distance_3d_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_to_segment_distance_3d_test
// Drives directed and random segment queries under varying handshake
// pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module point_to_segment_distance_3d_test;
  import pstsd_pkg::*;

  localparam int LATENCY   = 83;
  localparam int MAX_CYCLE = 200000;

  logic clk, rst_n, in_valid, out_stall;
  logic in_stall, out_valid, out_segment_degenerate;
  logic [CW-1:0] c [9];
  logic [RW-1:0] out_distance;
  int send_idle, recv_idle, cycle, fails, pending, seen, degs;

  point_to_segment_distance_3d dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_seg_a_x(c[0]), .in_seg_a_y(c[1]), .in_seg_a_z(c[2]),
    .in_seg_b_x(c[3]), .in_seg_b_y(c[4]), .in_seg_b_z(c[5]),
    .in_query_x(c[6]), .in_query_y(c[7]), .in_query_z(c[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_distance(out_distance), .out_segment_degenerate(out_segment_degenerate)
  );

  point_to_segment_distance_3d_checker chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_seg_a_x(c[0]), .in_seg_a_y(c[1]), .in_seg_a_z(c[2]),
    .in_seg_b_x(c[3]), .in_seg_b_y(c[4]), .in_seg_b_z(c[5]),
    .in_query_x(c[6]), .in_query_y(c[7]), .in_query_z(c[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_distance(out_distance), .out_segment_degenerate(out_segment_degenerate),
    .fail_count(fails), .pending(pending), .results_seen(seen),
    .degenerate_seen(degs)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    for (int i = 0; i < 9; i++) c[i] = '0;
  end

  always @(posedge clk) begin
    cycle <= (cycle === 'x) ? 1 : cycle + 1;
    out_stall <= ($urandom_range(99) < recv_idle);
    if (cycle > MAX_CYCLE) begin
      $display("point_to_segment_distance_3d_test failed");
      $finish;
    end
  end

  function automatic logic [CW-1:0] rand_coord(int mode);
    logic [CW-1:0] v;
    case (mode)
      0: v = CW'($urandom());
      1: v = CW'($signed($urandom_range(8192)) - 4096);
      2: v = $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
      default: v = CW'($signed($urandom_range(400000)) - 200000);
    endcase
    return v;
  endfunction

  // valid stays high after the accept; the task drops it for random idle gaps, the caller before a drain
  task automatic send(input logic [CW-1:0] v [9]);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) c[i] <= v[i];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic random_queries(int n);
    logic [CW-1:0] v [9];
    int mode, kind;
    for (int k = 0; k < n; k++) begin
      mode = $urandom_range(3);
      for (int i = 0; i < 9; i++) v[i] = rand_coord(mode);
      kind = $urandom_range(9);
      if (kind == 0) for (int i = 0; i < 3; i++) v[i+3] = v[i];
      else if (kind == 1) for (int i = 0; i < 3; i++) v[i+6] = v[i];
      else if (kind == 2) begin
        v[6] = v[0] - v[3] + v[0];
        v[7] = v[1] - v[4] + v[1];
        v[8] = v[2] - v[5] + v[2];
      end
      send(v);
    end
  endtask

  initial begin
    logic [CW-1:0] v [9];
    logic [CW-1:0] mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: zero, extremes, degenerate, tie, projection past end, on-line
    v = '{default: '0}; send(v);
    v = '{mx, mx, mx, mn, mn, mn, mx, mn, mx}; send(v);
    v = '{mn, mn, mn, mx, mx, mx, mn, mx, mn}; send(v);
    v = '{mx, mx, mx, mx, mx, mx, mn, mn, mn}; send(v);
    v = '{mn, mn, mn, mn, mn, mn, mx, mx, mx}; send(v);
    v = '{0, 0, 0, 4096, 0, 0, 2048, 4096, 0}; send(v);
    v = '{0, 0, 0, 4096, 0, 0, 12288, 0, 0}; send(v);
    v = '{0, 0, 0, 4096, 0, 0, -8192, 100, 0}; send(v);
    v = '{0, 0, 0, 4096, 4096, 0, 2048, 2048, 0}; send(v);
    v = '{-1, -1, -1, 1, 1, 1, 5, -7, 3}; send(v);
    v = '{0, 0, 0, 0, 0, 0, mx, mx, mx}; send(v);
    v = '{mx, 0, mn, mn, 0, mx, 0, mx, 0}; send(v);
    v = '{0, 0, 0, 8192, 0, 0, 8192, 8192, 0}; send(v);
    v = '{1, 2, 3, 1, 2, 4, 1, 2, 3}; send(v);
    send_idle = 29; recv_idle = 70;
    random_queries(550);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    send_idle = 70; recv_idle = 29;
    random_queries(550);
    send_idle = 0; recv_idle = 0;
    random_queries(550);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d results, %0d on degenerate segments, under three stall mixes.",
        seen, degs);
    if (fails == 0 && pending == 0)
      $display("point_to_segment_distance_3d_test passed");
    else
      $display("point_to_segment_distance_3d_test failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/pstsd_pkg.sv
rtl/pstsd_geom.sv
rtl/pstsd_div.sv
rtl/pstsd_sqrt.sv
rtl/point_to_segment_distance_3d.sv
tb/sv/point_to_segment_distance_3d_checker.sv
tb/sv/point_to_segment_distance_3d_test.sv
